// File: rtl/core/dtf_pkg.sv
// dtf_pkg: shared types and constants of the decimal text to fixed-point parser.
// Used by every module under rtl/core but dtf_queue; depends on nothing.
package dtf_pkg;

    // fixed widths of the ports
    localparam int VALUE_W   = 48;
    localparam int BYTE_W    = 8;
    localparam int TOL_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int INT_W     = 31;
    localparam int DIGIT_W   = 4;
    localparam int SUM_W     = VALUE_W + 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd2;

    // reset value of both bounds (-1.0 in Q16, check disabled)
    localparam logic [VALUE_W-1:0] BOUND_RESET = 48'hFFFF_FFFF_0000;

    // characters
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'd46;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

    // integer magnitude limit and 48-bit limits
    localparam logic [INT_W-1:0]             INT_SAT   = 31'h7FFF_FFFF;
    localparam logic [63:0]                  BIG_CAP   = 64'h0001_0000_0000_0000;
    localparam logic signed [SUM_W-1:0]      SUM_MAX48 = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0]      SUM_MIN48 = -50'sh0_8000_0000_0000;

    // queue depths
    localparam int TOKEN_DEPTH  = 4;
    localparam int RESULT_DEPTH = 2;

    // character classes
    typedef enum logic [2:0] {
        TK_END   = 3'd0,
        TK_BLANK = 3'd1,
        TK_MINUS = 3'd2,
        TK_PLUS  = 3'd3,
        TK_DIGIT = 3'd4,
        TK_DOT   = 3'd5,
        TK_OTHER = 3'd6
    } token_kind_t;

    typedef struct packed {
        token_kind_t          kind;
        logic [DIGIT_W-1:0]   digit;
    } token_t;

    // parser phases
    typedef enum logic [5:0] {
        PH_LEAD     = 6'b000001,
        PH_ATOI_WS  = 6'b000010,
        PH_ATOI_DIG = 6'b000100,
        PH_SKIP     = 6'b001000,
        PH_FRAC     = 6'b010000,
        PH_TAIL     = 6'b100000
    } phase_t;

    // sign and saturation marks of a finished number
    typedef struct packed {
        logic inner_neg;
        logic outer_neg;
        logic saturated;
    } flags_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_IDX_W-1:0]   index;
        logic [VALUE_W-1:0]     data;
    } cfg_write_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               out_of_range;
        logic               int_overflow;
    } result_t;

endpackage

// File: rtl/core/dtf_queue.sv
// dtf_queue: small register queue with first-word fall-through read.
// Depends on nothing; DEPTH must be a power of two.
module dtf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: rtl/core/dtf_front.sv
// dtf_front: takes text bytes, sorts each into a character class and queues it.
// Depends on dtf_pkg and dtf_queue.
module dtf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [dtf_pkg::BYTE_W-1:0]   text_byte,
    output logic                         full,
    output logic                         tok_valid,
    output dtf_pkg::token_t              tok,
    input  logic                         tok_pop
);
    import dtf_pkg::*;

    token_t                   tok_in;
    logic [$bits(token_t)-1:0] q_rdata;
    logic                     q_empty;
    logic                     is_blank;
    logic                     is_digit;

    // character classes
    assign is_blank = (text_byte == CH_SPACE) ||
                      ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);

    always_comb
    begin
        tok_in.digit = text_byte[DIGIT_W-1:0] - CH_ZERO[DIGIT_W-1:0];
        priority if (text_byte == CH_NUL)
        begin
            tok_in.kind = TK_END;
        end
        else if (is_blank)
        begin
            tok_in.kind = TK_BLANK;
        end
        else if (is_digit)
        begin
            tok_in.kind = TK_DIGIT;
        end
        else if (text_byte == CH_MINUS)
        begin
            tok_in.kind = TK_MINUS;
        end
        else if (text_byte == CH_PLUS)
        begin
            tok_in.kind = TK_PLUS;
        end
        else if (text_byte == CH_DOT)
        begin
            tok_in.kind = TK_DOT;
        end
        else
        begin
            tok_in.kind = TK_OTHER;
        end
    end

    // queue towards the parser
    dtf_queue #(
        .WIDTH ($bits(token_t)),
        .DEPTH (TOKEN_DEPTH)
    ) u_token_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (tok_in),
        .full  (full),
        .pop   (tok_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign tok_valid = !q_empty;
    assign tok       = token_t'(q_rdata);

endmodule

// File: rtl/core/dtf_parse.sv
// dtf_parse: parser state machine; builds integer part and Q fraction sum,
// hands a finished number to the finishing pipeline. Depends on dtf_pkg.
module dtf_parse #(
    parameter int FRACTION_BITS       = 16,
    parameter int MAX_FRACTION_DIGITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tok_valid,
    input  dtf_pkg::token_t             tok,
    output logic                        tok_pop,
    output logic                        fin_valid,
    input  logic                        fin_ready,
    output logic [dtf_pkg::INT_W-1:0]   fin_int,
    output logic [FRACTION_BITS:0]      fin_frac,
    output dtf_pkg::flags_t             fin_flags
);
    import dtf_pkg::*;

    localparam int FW     = FRACTION_BITS + 1;
    localparam int CW     = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int IW     = (MAX_FRACTION_DIGITS > 1) ? $clog2(MAX_FRACTION_DIGITS) : 1;
    localparam int TERM_W = FRACTION_BITS + DIGIT_W;
    localparam int PROD_W = INT_W + 4;

    // weight of the k-th fraction digit: round(2^FRACTION_BITS / 10^k)
    logic [FRACTION_BITS-1:0] step_tab [MAX_FRACTION_DIGITS];

    for (genvar k = 0; k < MAX_FRACTION_DIGITS; k++)
    begin : g_step
        localparam logic [63:0] POW  = 64'd10 ** (k + 1);
        localparam logic [63:0] STEP = ((64'd1 << FRACTION_BITS) + POW / 64'd2) / POW;
        assign step_tab[k] = STEP[FRACTION_BITS-1:0];
    end

    phase_t             phase_reg, phase_next;
    logic               outer_neg_reg, outer_neg_next;
    logic               inner_neg_reg, inner_neg_next;
    logic [INT_W-1:0]   int_reg, int_next;
    logic [FW-1:0]      frac_reg, frac_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               sat_reg, sat_next;

    logic               go_dig;
    logic               go_skip;
    logic               is_end;
    logic [PROD_W-1:0]  prod;
    logic [TERM_W-1:0]  term;

    // handshake with the token queue and the finishing pipeline
    assign is_end    = (tok.kind == TK_END);
    assign tok_pop   = tok_valid && (!is_end || fin_ready);
    assign fin_valid = tok_valid && is_end;
    assign fin_int   = int_reg;
    assign fin_frac  = frac_reg;
    assign fin_flags = '{inner_neg: inner_neg_reg, outer_neg: outer_neg_reg,
                         saturated: sat_reg};

    // times-ten step and fraction weight
    assign prod = (PROD_W'(int_reg) << 3) + (PROD_W'(int_reg) << 1) + PROD_W'(tok.digit);
    assign term = TERM_W'(tok.digit) * TERM_W'(step_tab[cnt_reg[IW-1:0]]);

    // next parser state for one character
    always_comb
    begin
        phase_next     = phase_reg;
        outer_neg_next = outer_neg_reg;
        inner_neg_next = inner_neg_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        go_dig         = 1'b0;
        go_skip        = 1'b0;
        if (tok_pop)
        begin
            if (is_end)
            begin
                phase_next     = PH_LEAD;
                outer_neg_next = 1'b0;
                inner_neg_next = 1'b0;
                int_next       = '0;
                frac_next      = '0;
                cnt_next       = '0;
                sat_next       = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        priority if (tok.kind == TK_BLANK)
                        begin
                        end
                        else if (tok.kind == TK_MINUS)
                        begin
                            outer_neg_next = 1'b1;
                            phase_next     = PH_ATOI_WS;
                        end
                        else if (tok.kind == TK_PLUS)
                        begin
                            phase_next = PH_ATOI_WS;
                        end
                        else
                        begin
                            go_dig = 1'b1;
                        end
                    end
                    PH_ATOI_WS:
                    begin
                        priority if (tok.kind == TK_BLANK)
                        begin
                        end
                        else if (tok.kind == TK_MINUS)
                        begin
                            inner_neg_next = 1'b1;
                            phase_next     = PH_ATOI_DIG;
                        end
                        else if (tok.kind == TK_PLUS)
                        begin
                            phase_next = PH_ATOI_DIG;
                        end
                        else
                        begin
                            go_dig = 1'b1;
                        end
                    end
                    PH_ATOI_DIG:
                    begin
                        go_dig = 1'b1;
                    end
                    PH_SKIP:
                    begin
                        go_skip = 1'b1;
                    end
                    PH_FRAC:
                    begin
                        if (tok.kind == TK_DIGIT)
                        begin
                            if (cnt_reg < CW'(MAX_FRACTION_DIGITS))
                            begin
                                cnt_next  = cnt_reg + 1'b1;
                                frac_next = frac_reg + term[FW-1:0];
                            end
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                    end
                    default:
                    begin
                    end
                endcase

                // integer digits, saturating at the 31-bit limit
                if (go_dig)
                begin
                    if (tok.kind == TK_DIGIT)
                    begin
                        phase_next = PH_ATOI_DIG;
                        if (prod > PROD_W'(INT_SAT))
                        begin
                            int_next = INT_SAT;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            int_next = prod[INT_W-1:0];
                        end
                    end
                    else
                    begin
                        go_skip = 1'b1;
                    end
                end

                // junk up to the decimal point
                if (go_skip)
                begin
                    phase_next = (tok.kind == TK_DOT) ? PH_FRAC : PH_SKIP;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            outer_neg_reg <= 1'b0;
            inner_neg_reg <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            outer_neg_reg <= outer_neg_next;
            inner_neg_reg <= inner_neg_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
        end
    end

    a_sat_holds_limit: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (int_reg == INT_SAT))
        else $error("saturation mark without saturated integer");

    a_frac_only_after_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> ((phase_reg == PH_FRAC) || (phase_reg == PH_TAIL)))
        else $error("fraction digits counted outside the fraction");

    a_end_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid && !fin_ready) |=> ($stable(int_reg) && $stable(frac_reg) &&
                                       $stable(phase_reg)))
        else $error("parser state moved while the finished number waited");

endmodule

// File: rtl/core/dtf_finish.sv
// dtf_finish: configuration registers, value assembly, 48-bit saturation,
// bound check and result queue. Depends on dtf_pkg and dtf_queue.
module dtf_finish #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtf_pkg::cfg_write_t           cfg_wr,
    input  logic                          fin_valid,
    output logic                          fin_ready,
    input  logic [dtf_pkg::INT_W-1:0]     fin_int,
    input  logic [FRACTION_BITS:0]        fin_frac,
    input  dtf_pkg::flags_t               fin_flags,
    output logic                          empty,
    input  logic                          pop,
    output dtf_pkg::result_t              result
);
    import dtf_pkg::*;

    // configuration and precomputed limits
    logic [VALUE_W-1:0]       lower_reg;
    logic [VALUE_W-1:0]       upper_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic signed [SUM_W-1:0]  lim_lo_reg, lim_lo_next;
    logic signed [SUM_W-1:0]  lim_hi_reg, lim_hi_next;
    logic                     lo_en_reg;
    logic                     hi_en_reg;

    // pipeline
    logic                     s1_valid_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg, s1_sum_next;
    logic                     s1_outer_reg;
    logic                     s1_sat_reg;
    logic                     s2_valid_reg;
    logic [VALUE_W-1:0]       s2_value_reg, s2_value_next;
    logic                     s2_sat_reg;

    logic                     s1_ready;
    logic                     s2_ready;
    logic [63:0]              big_full;
    logic [VALUE_W:0]         big_cap;
    logic signed [SUM_W-1:0]  s2_neg;
    logic signed [SUM_W-1:0]  s2_value_ext;
    logic                     bad;
    result_t                  res_in;
    logic [$bits(result_t)-1:0] q_rdata;
    logic                     q_full;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= BOUND_RESET;
            upper_reg <= BOUND_RESET;
            tol_reg   <= '0;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                REG_LOWER: lower_reg <= cfg_wr.data;
                REG_UPPER: upper_reg <= cfg_wr.data;
                REG_TOL:   tol_reg   <= cfg_wr.data[TOL_W-1:0];
                default:   ;
            endcase
        end
    end

    // bounds widened by the tolerance
    assign lim_lo_next = $signed({{(SUM_W-VALUE_W){lower_reg[VALUE_W-1]}}, lower_reg}) -
                         $signed(SUM_W'(tol_reg));
    assign lim_hi_next = $signed({{(SUM_W-VALUE_W){upper_reg[VALUE_W-1]}}, upper_reg}) +
                         $signed(SUM_W'(tol_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_lo_reg <= $signed({{(SUM_W-VALUE_W){1'b1}}, BOUND_RESET});
            lim_hi_reg <= $signed({{(SUM_W-VALUE_W){1'b1}}, BOUND_RESET});
            lo_en_reg  <= 1'b0;
            hi_en_reg  <= 1'b0;
        end
        else
        begin
            lim_lo_reg <= lim_lo_next;
            lim_hi_reg <= lim_hi_next;
            lo_en_reg  <= !lower_reg[VALUE_W-1];
            hi_en_reg  <= !upper_reg[VALUE_W-1];
        end
    end

    // pipeline flow
    assign s2_ready  = !s2_valid_reg || !q_full;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign fin_ready = s1_ready;

    // stage 1: scale and cap the integer, then add the fraction to it or subtract it from the fraction
    assign big_full = 64'(fin_int) << FRACTION_BITS;
    assign big_cap  = (big_full > BIG_CAP) ? BIG_CAP[VALUE_W:0] : big_full[VALUE_W:0];

    always_comb
    begin
        if (fin_flags.inner_neg)
        begin
            s1_sum_next = $signed(SUM_W'(fin_frac) - SUM_W'(big_cap));
        end
        else
        begin
            s1_sum_next = $signed(SUM_W'(big_cap) + SUM_W'(fin_frac));
        end
    end

    // stage 2: outer sign and 48-bit saturation
    assign s2_neg = s1_outer_reg ? -s1_sum_reg : s1_sum_reg;

    always_comb
    begin
        priority if (s2_neg > SUM_MAX48)
        begin
            s2_value_next = SUM_MAX48[VALUE_W-1:0];
        end
        else if (s2_neg < SUM_MIN48)
        begin
            s2_value_next = SUM_MIN48[VALUE_W-1:0];
        end
        else
        begin
            s2_value_next = s2_neg[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= fin_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && fin_valid)
        begin
            s1_sum_reg   <= s1_sum_next;
            s1_outer_reg <= fin_flags.outer_neg;
            s1_sat_reg   <= fin_flags.saturated;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_value_reg <= s2_value_next;
            s2_sat_reg   <= s1_sat_reg;
        end
    end

    // bound check on the way into the result queue
    assign s2_value_ext = $signed({{(SUM_W-VALUE_W){s2_value_reg[VALUE_W-1]}}, s2_value_reg});
    assign bad = (lo_en_reg && (s2_value_ext < lim_lo_reg)) ||
                 (hi_en_reg && (s2_value_ext > lim_hi_reg));

    assign res_in = '{value: s2_value_reg, out_of_range: bad, int_overflow: s2_sat_reg};

    dtf_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s2_valid_reg),
        .wdata (res_in),
        .full  (q_full),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (empty)
    );

    assign result = result_t'(q_rdata);

    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && q_full) |=> (s2_valid_reg && $stable(s2_value_reg)))
        else $error("stalled number left the last stage");

endmodule

// File: rtl/core/decimal_text_to_fixed.sv
// decimal_text_to_fixed: ASCII decimal text to signed Q fixed-point parser.
// Depends on dtf_pkg, dtf_front, dtf_parse, dtf_finish.
//
// Usage
//   Input channel: one text byte per item, taken when push is high and full
//   is low. A zero byte ends the number; other bytes give no result.
//   Result channel: number_value, out_of_range and int_overflow of the oldest
//   finished number are valid while empty is low; pop takes it.
//   Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 lower bound, 1 upper bound, 2 tolerance); cfg_ready is always high.
//   Write registers only while no number is in flight.
// Timing
//   One byte per cycle while full is low. A result passes from the token queue
//   through the assembly stage and the saturation stage into the result queue
//   before it shows on the result ports. The parser hands the zero byte on
//   in the cycle it reaches the head of the token queue, if stage 1 is ready.
// Reset
//   rst_n clears the parser, both queues and the pipeline; bounds return to
//   -1.0 (checks off) and the tolerance to zero.
// Stall
//   A held-off result fills the result queue and pipeline, then the parser
//   stops at the next zero byte and full rises once the token queue fills.
module decimal_text_to_fixed #(
    parameter int FRACTION_BITS       = 16,
    parameter int MAX_FRACTION_DIGITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [dtf_pkg::BYTE_W-1:0]       text_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [dtf_pkg::VALUE_W-1:0]      number_value,
    output logic                             out_of_range,
    output logic                             int_overflow,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dtf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dtf_pkg::VALUE_W-1:0]      cfg_data
);
    import dtf_pkg::*;

    token_t               tok;
    logic                 tok_valid;
    logic                 tok_pop;
    logic                 fin_valid;
    logic                 fin_ready;
    logic [INT_W-1:0]     fin_int;
    logic [FRACTION_BITS:0] fin_frac;
    flags_t               fin_flags;
    cfg_write_t           cfg_wr;
    result_t              result;

    // configuration write
    assign cfg_ready = 1'b1;
    assign cfg_wr    = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

    // classification and token queue
    dtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .full      (full),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    // parser
    dtf_parse #(
        .FRACTION_BITS       (FRACTION_BITS),
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_int   (fin_int),
        .fin_frac  (fin_frac),
        .fin_flags (fin_flags)
    );

    // value assembly, bound check, result queue
    dtf_finish #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_int   (fin_int),
        .fin_frac  (fin_frac),
        .fin_flags (fin_flags),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign number_value = result.value;
    assign out_of_range = result.out_of_range;
    assign int_overflow = result.int_overflow;

endmodule
